// File: sv/medf_pkg.sv
// Shared types and constants of the streaming median filter.
`default_nettype none

package medf_pkg;

   localparam int PIXEL_W        = 8;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 16;
   localparam int CSR_DATA_W     = 16;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      FUNC_PIXEL = 1'b0,
      FUNC_FLUSH = 1'b1
   } func_type;

   typedef struct packed {
      func_type  func;
      pixel_type pixel;
   } req_payload_type;

   typedef struct packed {
      pixel_type median;
      logic      last_of_frame;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: sv/medf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module medf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: sv/medf_median.sv
// Rank-select median of a window of N pixels (one compare layer, popcount, select).
`default_nettype none

module medf_median #(
   parameter int N = 9
) (
   input  wire logic [N*medf_pkg::PIXEL_W-1:0] window,
   output medf_pkg::pixel_type                 median
);

   localparam int MID = (N - 1) / 2;
   localparam int RW  = $clog2(N + 1);

   medf_pkg::pixel_type value [N];
   logic [N-1:0]        below [N];
   logic [RW-1:0]       rank  [N];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         value[i] = window[i*medf_pkg::PIXEL_W +: medf_pkg::PIXEL_W];
      end
   end

   // rank = count of smaller values, ties broken by position, so ranks are unique
   always_comb begin
      median = '0;
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            below[i][j] = (value[j] < value[i]) || ((j < i) && (value[j] == value[i]));
         end
         rank[i] = RW'($countones(below[i]));
         if (rank[i] == RW'(MID)) begin
            median = median | value[i];
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/median_filter_3x3.sv
// Streaming KERNEL x KERNEL median filter with zero padding, top level.
//
// Pixels enter on the req_ channel in raster order, one per transaction;
// func = flush advances the window without a pixel. Each transaction yields
// zero or one result on the rsp_ channel: the median for the position
// HALF rows and HALF columns behind the input, HALF = KERNEL/2. After a
// frame, flush transactions push out the remaining results; the one for
// the last pixel carries last_of_frame and all counters return to the
// frame start. A transaction is taken when valid is high and stall is low.
// Throughput is one transaction per cycle unless req_stall is high: a line
// RAM read for the current column, one window shift and a rank-select
// median, each in its own stage. A result moves from stage 1 through the
// window registers to the output register. When rsp_stall holds the output,
// internal stages fill until the line RAM stage is blocked; req_stall then rises.
// Reset (synchronous) empties the pipeline, clears the counters and loads
// width 640 and height 480. Writing csr_ registers restarts the counters;
// write only while idle. The line RAM is never cleared: rows from before
// the frame start are masked off as padding.
`default_nettype none

module median_filter_3x3 #(
   parameter int KERNEL    = 3,
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire medf_pkg::req_payload_type         req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output medf_pkg::rsp_payload_type              rsp_payload,
   input  wire logic                              csr_write,
   input  wire medf_pkg::csr_index_type           csr_index,
   input  wire logic [medf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int HALF  = KERNEL / 2;
   localparam int N     = KERNEL * KERNEL;
   localparam int LANES = KERNEL - 1;
   localparam int PW    = medf_pkg::PIXEL_W;
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int LW    = $clog2(HALF * MAX_WIDTH + HALF + 1);
   localparam int HW    = medf_pkg::FRAME_HEIGHT_W;
   localparam int IRW   = HW + 1;
   localparam int RSW   = HW + 2;
   localparam int CSW   = WW + 2;

   // configuration and position state
   logic [medf_pkg::FRAME_WIDTH_W-1:0] frame_width_ff;
   logic [HW-1:0]                      frame_height_ff;
   logic [WW-1:0]                      in_col_ff, in_col_in;
   logic [IRW-1:0]                     in_row_ff, in_row_in;
   logic [WW-1:0]                      out_col_ff, out_col_in;
   logic [HW-1:0]                      out_row_ff, out_row_in;
   logic [LW-1:0]                      lead_ff, lead_in;

   logic [WW-1:0] eff_w;
   logic [HW-1:0] eff_h;
   logic [LW-1:0] lag;

   logic accept, s1_go, s2_go;
   logic has_result, is_last;
   logic [KERNEL-1:0] rmask, cmask;
   logic [RSW-1:0]    rsum [KERNEL];
   logic [CSW-1:0]    csum [KERNEL];
   medf_pkg::pixel_type in_px;

   // stage 1: accepted item plus line RAM column
   logic                       s1_valid_ff;
   medf_pkg::pixel_type        s1_px_ff;
   logic [AW-1:0]              s1_addr_ff;
   logic                       s1_result_ff;
   logic                       s1_last_ff;
   logic [KERNEL-1:0]          s1_rmask_ff, s1_cmask_ff;
   logic                       s1_byp_ff;
   logic [LANES*PW-1:0]        s1_byp_word_ff;
   logic [LANES*PW-1:0]        ram_rd_data;
   logic [LANES*PW-1:0]        rd_word;
   logic [LANES*PW-1:0]        wr_word;
   medf_pkg::pixel_type        new_col [KERNEL];

   // stage 2: window registers
   logic                       s2_valid_ff;
   logic                       s2_last_ff;
   logic [KERNEL-1:0]          s2_rmask_ff, s2_cmask_ff;
   medf_pkg::pixel_type        win_ff [KERNEL][KERNEL];
   logic [N*PW-1:0]            win_masked;
   medf_pkg::pixel_type        med;

   // stage 3: output register
   logic                       s3_valid_ff;
   medf_pkg::rsp_payload_type  rsp_payload_ff;

   // ---------------------------------------------------------------- frame geometry
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(frame_width_ff);
      end
      eff_h = (frame_height_ff == '0) ? HW'(1) : frame_height_ff;
      lag   = LW'(HALF * 32'(eff_w) + HALF);
   end

   // ---------------------------------------------------------------- handshake
   assign s2_go     = s2_valid_ff && (!s3_valid_ff || !rsp_stall);
   assign s1_go     = s1_valid_ff && (!s2_valid_ff || s2_go);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------- position logic
   assign has_result = (lead_ff == lag);
   assign is_last    = has_result && (out_row_ff == eff_h - HW'(1))
                       && (out_col_ff == eff_w - WW'(1));

   always_comb begin
      in_px = '0;
      if ((req_payload.func == medf_pkg::FUNC_PIXEL) && (32'(in_row_ff) < 32'(eff_h))) begin
         in_px = req_payload.pixel;
      end
      for (int k = 0; k < KERNEL; k++) begin
         rsum[k]  = RSW'(out_row_ff) + RSW'(k);
         rmask[k] = (rsum[k] >= RSW'(HALF)) && (rsum[k] < RSW'(eff_h) + RSW'(HALF));
         csum[k]  = CSW'(out_col_ff) + CSW'(k);
         cmask[k] = (csum[k] >= CSW'(HALF)) && (csum[k] < CSW'(eff_w) + CSW'(HALF));
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lead_in    = lead_ff;
      if (csr_write) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lead_in    = '0;
      end else if (accept) begin
         if (is_last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            lead_in    = '0;
         end else begin
            if (has_result) begin
               if (out_col_ff + WW'(1) >= eff_w) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + HW'(1);
               end else begin
                  out_col_in = out_col_ff + WW'(1);
               end
            end else begin
               lead_in = lead_ff + LW'(1);
            end
            if (in_col_ff + WW'(1) >= eff_w) begin
               in_col_in = '0;
               in_row_in = in_row_ff + IRW'(1);
            end else begin
               in_col_in = in_col_ff + WW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= medf_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= medf_pkg::FRAME_HEIGHT_RESET;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         lead_ff         <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               medf_pkg::CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_wdata[medf_pkg::FRAME_WIDTH_W-1:0];
               end
               medf_pkg::CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_wdata[HW-1:0];
               end
               default: begin
               end
            endcase
         end
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lead_ff    <= lead_in;
      end
   end

   // ---------------------------------------------------------------- line RAM
   // Each word holds the column of the KERNEL-1 previous rows, newest in lane 0.
   medf_ram #(
      .WIDTH (LANES * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (in_col_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // same-cycle write and read of one column (width of one) reads stale data
   assign rd_word = s1_byp_ff ? s1_byp_word_ff : ram_rd_data;

   always_comb begin
      wr_word[PW-1:0] = s1_px_ff;
      for (int k = 1; k < LANES; k++) begin
         wr_word[k*PW +: PW] = rd_word[(k-1)*PW +: PW];
      end
      for (int dy = 0; dy < KERNEL - 1; dy++) begin
         new_col[dy] = rd_word[(KERNEL-2-dy)*PW +: PW];
      end
      new_col[KERNEL-1] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= in_px;
         s1_addr_ff     <= in_col_ff[AW-1:0];
         s1_result_ff   <= has_result;
         s1_last_ff     <= is_last;
         s1_rmask_ff    <= rmask;
         s1_cmask_ff    <= cmask;
         s1_byp_ff      <= s1_go && (s1_addr_ff == in_col_ff[AW-1:0]);
         s1_byp_word_ff <= wr_word;
      end
   end

   // ---------------------------------------------------------------- window
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_go) begin
         s2_valid_ff <= s1_result_ff;
      end else if (s2_go) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_last_ff  <= s1_last_ff;
         s2_rmask_ff <= s1_rmask_ff;
         s2_cmask_ff <= s1_cmask_ff;
         for (int d = KERNEL - 1; d > 0; d--) begin
            win_ff[d] <= win_ff[d-1];
         end
         win_ff[0] <= new_col;
      end
   end

   // shift depth d holds column offset KERNEL-1-d of the output window
   always_comb begin
      for (int d = 0; d < KERNEL; d++) begin
         for (int dy = 0; dy < KERNEL; dy++) begin
            win_masked[(d*KERNEL+dy)*PW +: PW] =
               (s2_rmask_ff[dy] && s2_cmask_ff[KERNEL-1-d]) ? win_ff[d][dy] : '0;
         end
      end
   end

   medf_median #(
      .N (N)
   ) u_median (
      .window (win_masked),
      .median (med)
   );

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s2_go) begin
         s3_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         s3_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         rsp_payload_ff.median        <= med;
         rsp_payload_ff.last_of_frame <= s2_last_ff;
      end
   end

   assign rsp_valid   = s3_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------- checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty first stage");

   a_out_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      (out_col_ff < eff_w) && (in_col_ff < eff_w))
      else $error("column counter outside frame width");

   a_out_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      out_row_ff < eff_h)
      else $error("output row outside frame height");

   a_lead_bounded: assert property (@(posedge clock) disable iff (reset)
      lead_ff <= lag)
      else $error("startup lead counter passed its limit");

   a_pending_result_kept: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_go) |=> s2_valid_ff)
      else $error("pending window result dropped");

endmodule

`default_nettype wire
